// File: rtl/core/mxt_pkg.sv
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared codes and types for the max-extract table: command and status
// codes, and the control group that drives the running-maximum scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mxt_pkg;

  // command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // width of the occupancy field
  localparam int OCC_W = 6;

  // control for the scan unit, one per returned read word
  typedef struct packed {
    logic valid;  // read data word is present this cycle
    logic first;  // word comes from entry zero
  } scan_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/max_extract_table.sv
// ----------------------------------------------------------------------------
// max_extract_table
// Unsorted table of 8-bit values with insert and extract-maximum commands.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with in_cmd and in_value; each
//   request yields exactly one result on out_valid/out_ready carrying
//   out_removed_value, out_status and out_occupancy.
//   Insert: the value is written at the end of the table in the accept
//   cycle; the result goes through the post state into the output register.
//   Extract: the table memory is read one entry per cycle, and the rate is
//   set by the single read port of the table memory. The largest value is
//   removed by moving the last stored entry into its slot, one write at
//   the end of the scan. Extract on an empty table and insert on a full
//   table finish with status empty or full and leave the table unchanged.
//   One request is in flight at a time; the result sits in an output
//   register, and a stalled receiver keeps the next result waiting in the
//   post state, with no request after it accepted until that result moves on.
//   Reset empties the table at once; no clearing pass is needed, since
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_extract_table #(
  parameter int CAPACITY = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_cmd,
  input  wire logic [7:0]               in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [7:0]               out_removed_value,
  output logic      [1:0]               out_status,
  output logic      [mxt_pkg::OCC_W-1:0] out_occupancy
);

  import mxt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_POST = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic [7:0]        res_val_r, res_val_nxt;
  logic [1:0]        res_st_r, res_st_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_val_r, out_val_nxt;
  logic [1:0]        out_st_r, out_st_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  scan_ctrl_t        scan_ctrl;
  logic [7:0]        cur_max;
  logic [AW-1:0]     cur_best;
  logic              last_word;
  logic              in_acc;
  logic              out_free;

  // table storage
  mxt_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // running maximum over the returned words
  assign scan_ctrl.valid = rvalid_r;
  assign scan_ctrl.first = (ridx_r == '0);

  mxt_max_scan #(
    .AW (AW)
  ) u_scan (
    .clk      (clk),
    .ctrl     (scan_ctrl),
    .data     (ram_rdata),
    .idx      (ridx_r),
    .cur_max  (cur_max),
    .cur_best (cur_best)
  );

  // handshake terms
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last_word = rvalid_r && ((CW'(ridx_r) + CW'(1)) == count_r);

  // sequencer: accept, scan, post
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    issue_nxt   = issue_r;
    rvalid_nxt  = 1'b0;
    ridx_nxt    = ridx_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_wdata   = in_value;
    ram_re      = 1'b0;
    ram_raddr   = issue_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_val_nxt = 8'd0;
          res_st_nxt  = ST_DONE;
          state_nxt   = S_POST;
          if (in_cmd == CMD_INSERT) begin
            if (count_r >= CAP_C) begin
              res_st_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = ST_EMPTY;
            end else begin
              issue_nxt = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // one read per cycle until every stored entry is issued
        if (issue_r < count_r) begin
          ram_re     = 1'b1;
          rvalid_nxt = 1'b1;
          ridx_nxt   = issue_r[AW-1:0];
          issue_nxt  = issue_r + CW'(1);
        end
        // last word back: move it into the slot of the maximum
        if (last_word) begin
          ram_we      = 1'b1;
          ram_waddr   = cur_best;
          ram_wdata   = ram_rdata;
          count_nxt   = count_r - CW'(1);
          res_val_nxt = cur_max;
          state_nxt   = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_occ_nxt   = out_occ_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_POST) && out_free) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_st_nxt    = res_st_r;
      out_occ_nxt   = OCC_W'(count_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    issue_r   <= issue_nxt;
    ridx_r    <= ridx_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    out_occ_r <= out_occ_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_val_r;
  assign out_status        = out_st_r;
  assign out_occupancy     = out_occ_r;

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("stored count above capacity");

  // read and write of the table never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  // an insert into a table with room grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_INSERT) && (count_r < CAP_C))
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count");

  // a failed request reports no removed value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_DONE)) |-> (out_val_r == 8'd0))
    else $error("failed request carries a value");

  // the scan ends with a result posted
  a_scan_posts: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && last_word) |=> (state_r == S_POST))
    else $error("scan end did not post a result");

endmodule

`default_nettype wire

// File: rtl/core/mxt_ram.sv
// ----------------------------------------------------------------------------
// mxt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No reset on the contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mxt_max_scan.sv
// ----------------------------------------------------------------------------
// mxt_max_scan
// Running maximum over a stream of read words. Strictly greater replaces,
// so the earliest copy of the maximum is kept. The outputs give the combined
// value that includes the current word, for the final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mxt_max_scan #(
  parameter int AW = 5
) (
  input  wire logic                clk,
  input  wire mxt_pkg::scan_ctrl_t ctrl,
  input  wire logic [7:0]          data,
  input  wire logic [AW-1:0]       idx,
  output logic      [7:0]          cur_max,
  output logic      [AW-1:0]       cur_best
);

  import mxt_pkg::*;

  logic [7:0]    max_r;
  logic [AW-1:0] best_r;
  logic          take;

  // compare the incoming word against the best so far
  assign take     = ctrl.first || (data > max_r);
  assign cur_max  = take ? data : max_r;
  assign cur_best = take ? idx : best_r;

  // hold the best word and its index
  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      max_r  <= cur_max;
      best_r <= cur_best;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: max_extract_table testbench
// Sends insert and extract requests in bursts while the result side stalls
// on its own pattern, including one long hold that backs up the input.
// Every result is checked, field by field, against an in-order prediction.
// A short directed table covers the extremes, the empty and duplicate cases.
// Random phases then fill, drain and churn the table so that it reaches the
// full and empty states many times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mxt_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_AT = 3000;
  localparam int NUM_ROWS     = 19;

  typedef struct packed {
    logic [7:0]       removed;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
  } table_result_t;

  typedef struct packed {
    logic          cmd;
    logic [7:0]    value;
    logic          typed;
    table_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_cmd = CMD_INSERT;
  logic [7:0] in_value = 8'd0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [7:0] out_removed_value;
  logic [1:0] out_status;
  logic [OCC_W-1:0] out_occupancy;

  // predicted table contents and fill level
  logic [7:0] model_entries [CAPACITY];
  int unsigned model_count = 0;

  table_result_t expected_results [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;

  // receiver stall state
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int pattern_phase = 0;
  bit long_hold_done = 1'b0;

  // directed requests; typed rows carry an expectation read off by hand
  dir_row_t dir_rows [0:NUM_ROWS-1] = '{
    '{CMD_EXTRACT, 8'd0,   1'b1, '{8'd0,   ST_EMPTY, 6'd0}},
    '{CMD_INSERT,  8'd0,   1'b1, '{8'd0,   ST_DONE,  6'd1}},
    '{CMD_INSERT,  8'd255, 1'b1, '{8'd0,   ST_DONE,  6'd2}},
    '{CMD_INSERT,  8'd128, 1'b1, '{8'd0,   ST_DONE,  6'd3}},
    '{CMD_EXTRACT, 8'd0,   1'b1, '{8'd255, ST_DONE,  6'd2}},
    '{CMD_EXTRACT, 8'd0,   1'b1, '{8'd128, ST_DONE,  6'd1}},
    '{CMD_EXTRACT, 8'd0,   1'b1, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'd255, 1'b1, '{8'd0,   ST_EMPTY, 6'd0}},
    '{CMD_INSERT,  8'd1,   1'b1, '{8'd0,   ST_DONE,  6'd1}},
    '{CMD_INSERT,  8'd127, 1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_INSERT,  8'd127, 1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_INSERT,  8'd254, 1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'hAA,  1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'd0,   1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'd0,   1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_INSERT,  8'h55,  1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'd0,   1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'd0,   1'b0, '{8'd0,   ST_DONE,  6'd0}},
    '{CMD_EXTRACT, 8'd0,   1'b1, '{8'd0,   ST_EMPTY, 6'd0}}
  };

  max_extract_table #(.CAPACITY(CAPACITY)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // apply one request to the predicted table, earliest copy of the max goes
  function automatic table_result_t apply_request(logic cmd, logic [7:0] value);
    table_result_t res;
    int unsigned best;
    res.removed = 8'd0;
    res.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (model_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        model_entries[model_count] = value;
        model_count++;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int unsigned i = 1; i < model_count; i++) begin
        if (model_entries[i] > model_entries[best]) best = i;
      end
      res.removed = model_entries[best];
      // remaining values keep their order
      for (int unsigned i = best; i + 1 < model_count; i++) begin
        model_entries[i] = model_entries[i + 1];
      end
      model_count--;
    end
    res.occupancy = model_count[OCC_W-1:0];
    return res;
  endfunction

  // offer one request in bursts with random gaps, record its expectation
  task automatic send_request(input logic cmd, input logic [7:0] value,
                              input logic typed, input table_result_t want);
    table_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(cmd, value);
    if (typed) predicted = want;
    expected_results = {expected_results, predicted};
    burst_left--;
  endtask

  // receiver: stall modes, rare holds, and one long hold to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && cycle_count >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = 500;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4999) == 0) begin
      hold_left = $urandom_range(80, 250);
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      pattern_phase++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (pattern_phase % 4 == 0);
      endcase
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: removed=%0d status=%0d occupancy=%0d",
                   out_removed_value, out_status, out_occupancy);
      end else begin
        want = expected_results.pop_front();
        if (out_removed_value !== want.removed || out_status !== want.status ||
            out_occupancy !== want.occupancy) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: expected removed=%0d status=%0d occupancy=%0d,",
                      " got removed=%0d status=%0d occupancy=%0d"},
                     want.removed, want.status, want.occupancy,
                     out_removed_value, out_status, out_occupancy);
        end
      end
    end
  end

  // stimulus: reset, directed table, random phases, drain
  initial begin
    int sent;
    int phase_kind;
    int phase_len;
    int insert_pct;
    int pick;
    logic cmd;
    logic [7:0] value;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_request(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].typed,
                   dir_rows[r].want);
    end

    // random phases: fill, drain, balanced, and balanced with many duplicates
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 3);
      phase_len = $urandom_range(15, 90);
      case (phase_kind)
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
        pick = $urandom_range(0, 9);
        if (pick == 0) value = 8'd0;
        else if (pick == 1) value = 8'd255;
        else if (phase_kind == 3) value = 8'($urandom_range(100, 103));
        else value = 8'($urandom_range(0, 255));
        send_request(cmd, value, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // wait for the outstanding results, then let the block settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
